### rtl/core/gfnc_pkg.sv
// gfnc_pkg: shared constants, types and register indexes for the grid
// four-neighbor count block. No dependencies.
`timescale 1ns / 1ps

package gfnc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W   = 11;                  // grid_width / grid_height registers
    localparam int COORD_W = 10;                  // tile_col / tile_row
    localparam int CNT_W   = 3;                   // neighbor_count, 0..4
    localparam int ADDR_W  = $clog2(MAX_WIDTH);   // line buffer address
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = DIM_W;
    localparam int NUM_RES = 3;                   // results one tile can release

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 4'd0,
        REG_GRID_HEIGHT = 4'd1
    } t_reg_idx;

    typedef logic [DIM_W-1:0]   t_dim;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [ADDR_W-1:0]  t_addr;

    // One line buffer column: bit of the row above and of the row two above.
    typedef struct packed {
        logic older;
        logic prev;
    } t_line_entry;

    typedef struct packed {
        logic        we;
        t_addr       waddr;
        t_line_entry wdata;
        t_addr       raddr_cur;
        t_addr       raddr_next;
    } t_lb_ctrl;

    typedef struct packed {
        logic [CNT_W-1:0] neighbor_count;
        t_coord           tile_col;
        t_coord           tile_row;
        logic             frame_last;
    } t_result;

endpackage

### rtl/core/gfnc_if.sv
// gfnc_if: valid/ready channel interfaces for tiles in, counts out and
// register writes. Depends on gfnc_pkg.
`timescale 1ns / 1ps

interface gfnc_tile_if;
    logic valid;
    logic ready;
    logic tile_set;

    modport source (output valid, output tile_set, input ready);
    modport sink   (input valid, input tile_set, output ready);
endinterface

interface gfnc_result_if;
    logic                        valid;
    logic                        ready;
    logic [gfnc_pkg::CNT_W-1:0]  neighbor_count;
    gfnc_pkg::t_coord            tile_col;
    gfnc_pkg::t_coord            tile_row;
    logic                        frame_last;

    modport source (output valid, output neighbor_count, output tile_col,
                    output tile_row, output frame_last, input ready);
    modport sink   (input valid, input neighbor_count, input tile_col,
                    input tile_row, input frame_last, output ready);
endinterface

interface gfnc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gfnc_pkg::CFG_IDX_W-1:0]   index;
    logic [gfnc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/gfnc_line_buf.sv
// gfnc_line_buf: two-bit-wide line buffer RAM, one write and two registered
// reads per cycle, with write-to-read bypass. Depends on gfnc_pkg.
`timescale 1ns / 1ps

module gfnc_line_buf (
    input  logic                   i_clk,
    input  gfnc_pkg::t_lb_ctrl     i_ctrl,
    output gfnc_pkg::t_line_entry  o_rd_cur,
    output gfnc_pkg::t_line_entry  o_rd_next
);

    gfnc_pkg::t_line_entry r_mem [gfnc_pkg::MAX_WIDTH];
    gfnc_pkg::t_line_entry r_rd_cur;
    gfnc_pkg::t_line_entry r_rd_next;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.waddr] <= i_ctrl.wdata;
        end
    end

    // same-address write wins (narrow grids of one or two columns)
    always_ff @(posedge i_clk) begin
        if (i_ctrl.we && (i_ctrl.waddr == i_ctrl.raddr_cur)) begin
            r_rd_cur <= i_ctrl.wdata;
        end else begin
            r_rd_cur <= r_mem[i_ctrl.raddr_cur];
        end
        if (i_ctrl.we && (i_ctrl.waddr == i_ctrl.raddr_next)) begin
            r_rd_next <= i_ctrl.wdata;
        end else begin
            r_rd_next <= r_mem[i_ctrl.raddr_next];
        end
    end

    assign o_rd_cur  = r_rd_cur;
    assign o_rd_next = r_rd_next;

endmodule

### rtl/core/gfnc_count.sv
// gfnc_count: neighbor counts for the up to three tiles released by one
// input tile. Pure combinational. Depends on gfnc_pkg.
`timescale 1ns / 1ps

module gfnc_count (
    input  logic                                     i_tile_set,
    input  gfnc_pkg::t_coord                         i_col,
    input  gfnc_pkg::t_coord                         i_row,
    input  gfnc_pkg::t_dim                           i_width,
    input  gfnc_pkg::t_dim                           i_height,
    input  logic [1:0]                               i_left_bits,
    input  logic                                     i_up_left,
    input  gfnc_pkg::t_line_entry                    i_cur,
    input  gfnc_pkg::t_line_entry                    i_next,
    output gfnc_pkg::t_result [gfnc_pkg::NUM_RES-1:0] o_res,
    output logic [gfnc_pkg::NUM_RES-1:0]             o_mask,
    output logic                                     o_last_col,
    output logic                                     o_last_row
);

    localparam int CW = gfnc_pkg::CNT_W;

    logic row_ge1, row_ge2, col_ge1, col_ge2, has_right;
    logic [CW-1:0] cnt_above, cnt_left, cnt_final;

    always_comb begin
        row_ge1    = (i_row != '0);
        row_ge2    = (i_row > gfnc_pkg::t_coord'(1));
        col_ge1    = (i_col != '0);
        col_ge2    = (i_col > gfnc_pkg::t_coord'(1));
        has_right  = ({1'b0, i_col} + gfnc_pkg::t_dim'(1)) < i_width;
        o_last_col = ({1'b0, i_col} + gfnc_pkg::t_dim'(1)) == i_width;
        o_last_row = ({1'b0, i_row} + gfnc_pkg::t_dim'(1)) == i_height;

        // tile above: down = this beat, up = row two back, sides = row above
        cnt_above = CW'(i_tile_set) + CW'(row_ge2 & i_cur.older)
                  + CW'(col_ge1 & i_up_left) + CW'(has_right & i_next.prev);
        // last-row tile to the left: right = this beat
        cnt_left  = CW'(i_tile_set) + CW'(row_ge1 & i_up_left)
                  + CW'(col_ge2 & i_left_bits[1]);
        // final tile of the grid
        cnt_final = CW'(row_ge1 & i_cur.prev) + CW'(col_ge1 & i_left_bits[0]);

        o_mask[0] = row_ge1;
        o_mask[1] = o_last_row & col_ge1;
        o_mask[2] = o_last_row & o_last_col;

        o_res[0].neighbor_count = cnt_above;
        o_res[0].tile_col       = i_col;
        o_res[0].tile_row       = i_row - gfnc_pkg::t_coord'(1);
        o_res[0].frame_last     = 1'b0;

        o_res[1].neighbor_count = cnt_left;
        o_res[1].tile_col       = i_col - gfnc_pkg::t_coord'(1);
        o_res[1].tile_row       = i_row;
        o_res[1].frame_last     = 1'b0;

        o_res[2].neighbor_count = cnt_final;
        o_res[2].tile_col       = i_col;
        o_res[2].tile_row       = i_row;
        o_res[2].frame_last     = 1'b1;
    end

endmodule

### rtl/core/gfnc_res_queue.sv
// gfnc_res_queue: result register holding the up to three results of one tile,
// delivered in order, one per cycle while ready. Depends on gfnc_pkg, gfnc_if.
`timescale 1ns / 1ps

module gfnc_res_queue (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  gfnc_pkg::t_result [gfnc_pkg::NUM_RES-1:0] i_res,
    input  logic [gfnc_pkg::NUM_RES-1:0]             i_mask,
    output logic                                     o_load_ready,
    gfnc_result_if.source                            o_result
);

    gfnc_pkg::t_result [gfnc_pkg::NUM_RES-1:0] r_slot;
    logic [gfnc_pkg::NUM_RES-1:0]             r_mask;
    logic [gfnc_pkg::NUM_RES-1:0]             n_mask;
    logic [gfnc_pkg::NUM_RES-1:0]             head_bit;
    logic [gfnc_pkg::NUM_RES-1:0]             remain;
    gfnc_pkg::t_result                         head;
    logic                                      pop;

    always_comb begin
        priority if (r_mask[0]) begin
            head_bit = 3'b001;
            head     = r_slot[0];
        end else if (r_mask[1]) begin
            head_bit = 3'b010;
            head     = r_slot[1];
        end else begin
            head_bit = r_mask & 3'b100;
            head     = r_slot[2];
        end
        pop          = o_result.valid && o_result.ready;
        remain       = pop ? (r_mask & ~head_bit) : r_mask;
        o_load_ready = (remain == '0);
        n_mask       = i_load ? i_mask : remain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_res;
        end
    end

    assign o_result.valid          = (r_mask != '0);
    assign o_result.neighbor_count = head.neighbor_count;
    assign o_result.tile_col       = head.tile_col;
    assign o_result.tile_row       = head.tile_row;
    assign o_result.frame_last     = head.frame_last;

endmodule

### rtl/core/grid_four_neighbor_count.sv
// grid_four_neighbor_count: top level, raster position, register file and
// per-row state. Depends on gfnc_pkg, gfnc_if, gfnc_line_buf, gfnc_count,
// gfnc_res_queue.
`timescale 1ns / 1ps

// Streams a binary grid in raster order, one tile bit per beat, and returns
// for each tile the number (0..4) of set up/down/left/right neighbors inside
// the grid, with its column, row and a frame_last flag on the grid's final
// tile. A tile is reported when the tile below it arrives, so counts trail
// the input by one row; tiles of the last row are reported as their right
// neighbor arrives and the row's final tile with itself. The block takes one
// tile per clock while results drain: each beat goes through one level of
// count logic into a three-entry result register, and the next beat is
// taken as soon as that register drains. Rows above the last give at most
// one result per beat and run at full rate; in the last row each beat from
// column 1 on gives up to two results, and the row's final beat up to three
// (one fewer in a single-row grid), so there the input stalls until the
// result register has drained. Two rows of history live in one 1024 x 2
// line buffer RAM read at two columns each cycle. Writing either register
// restarts the grid at tile (0,0); a value of 0 is taken as 1 and a value
// above 1024 as 1024. Reset gives a 64 x 64 grid.

module grid_four_neighbor_count (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gfnc_tile_if.sink     i_tile,
    gfnc_cfg_if.sink      i_cfg,
    gfnc_result_if.source o_result
);

    localparam gfnc_pkg::t_dim DIM_RESET = gfnc_pkg::t_dim'(64);

    // grid size
    gfnc_pkg::t_dim   r_width, n_width;
    gfnc_pkg::t_dim   r_height, n_height;
    // raster position of the next beat and current-row history
    gfnc_pkg::t_coord r_col, n_col;
    gfnc_pkg::t_coord r_row, n_row;
    logic [1:0]       r_left_bits, n_left_bits;  // bit0: col-1, bit1: col-2
    logic             r_up_left;                 // row above at col-1

    logic                  accept, cfg_fire, restart, load_ready;
    logic                  last_col, last_row;
    gfnc_pkg::t_lb_ctrl    lb_ctrl;
    gfnc_pkg::t_line_entry rd_cur, rd_next;
    gfnc_pkg::t_result [gfnc_pkg::NUM_RES-1:0] res;
    logic [gfnc_pkg::NUM_RES-1:0]             res_mask;

    function automatic gfnc_pkg::t_dim clamp_dim(input gfnc_pkg::t_dim value,
                                                 input gfnc_pkg::t_dim maxv);
        gfnc_pkg::t_dim v;
        v = value;
        if (v == '0) v = gfnc_pkg::t_dim'(1);
        if (v > maxv) v = maxv;
        return v;
    endfunction

    assign i_cfg.ready  = 1'b1;
    assign i_tile.ready = load_ready;
    assign accept       = i_tile.valid && load_ready;
    assign cfg_fire     = i_cfg.valid;

    // register writes
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        restart  = 1'b0;
        if (cfg_fire) begin
            unique case (i_cfg.index)
                gfnc_pkg::REG_GRID_WIDTH: begin
                    n_width = clamp_dim(i_cfg.data, gfnc_pkg::t_dim'(gfnc_pkg::MAX_WIDTH));
                    restart = 1'b1;
                end
                gfnc_pkg::REG_GRID_HEIGHT: begin
                    n_height = clamp_dim(i_cfg.data,
                                         gfnc_pkg::t_dim'(gfnc_pkg::MAX_HEIGHT));
                    restart = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // raster position
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_left_bits = r_left_bits;
        priority if (!i_rst_n || restart) begin
            n_col       = '0;
            n_row       = '0;
            n_left_bits = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col       = '0;
                n_left_bits = '0;
                n_row       = last_row ? '0 : r_row + gfnc_pkg::t_coord'(1);
            end else begin
                n_col       = r_col + gfnc_pkg::t_coord'(1);
                n_left_bits = {r_left_bits[0], i_tile.tile_set};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_RESET;
            r_height    <= DIM_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_left_bits <= '0;
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_left_bits <= n_left_bits;
        end
    end

    // row-above bit of the previous column, same row only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_left <= rd_cur.prev;
        end
    end

    // line buffer: shift this column down one row, fetch the next two columns
    always_comb begin
        lb_ctrl.we          = accept;
        lb_ctrl.waddr       = gfnc_pkg::t_addr'(r_col);
        lb_ctrl.wdata.older = rd_cur.prev;
        lb_ctrl.wdata.prev  = i_tile.tile_set;
        lb_ctrl.raddr_cur   = gfnc_pkg::t_addr'(n_col);
        lb_ctrl.raddr_next  = gfnc_pkg::t_addr'(n_col) + gfnc_pkg::t_addr'(1);
    end

    gfnc_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_ctrl    (lb_ctrl),
        .o_rd_cur  (rd_cur),
        .o_rd_next (rd_next)
    );

    gfnc_count u_count (
        .i_tile_set  (i_tile.tile_set),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_left_bits (r_left_bits),
        .i_up_left   (r_up_left),
        .i_cur       (rd_cur),
        .i_next      (rd_next),
        .o_res       (res),
        .o_mask      (res_mask),
        .o_last_col  (last_col),
        .o_last_row  (last_row)
    );

    gfnc_res_queue u_res_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_res        (res),
        .i_mask       (res_mask),
        .o_load_ready (load_ready),
        .o_result     (o_result)
    );

endmodule
